// ----- design/slhm_pkg.sv -----
package slhm_pkg;

  // stream widths, padded to whole bytes
  localparam int unsigned InTdataW  = 112;
  localparam int unsigned OutTdataW = 160;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [28:0] HbId = 29'h0700_0001;

  // command frames, sent on identifier 0x06000001 with length 8
  localparam logic [63:0] FrameDisable = 64'h230C_2001_0000_0000;
  localparam logic [63:0] FrameEnable  = 64'h230D_2001_0000_0000;
  localparam logic [63:0] FrameSpeed   = 64'h2300_2001_0000_0000;

  localparam int SpeedMax = 998;
  localparam int SpeedMin = -995;

  typedef enum logic [2:0] {
    KIND_RX       = 3'd0,
    KIND_TICK     = 3'd1,
    KIND_DRIVE    = 3'd2,
    KIND_STOP     = 3'd3,
    KIND_PEAK_CLR = 3'd4
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STALE      = 3'd0,
    CFG_KEEPALIVE  = 3'd1,
    CFG_SCALE      = 3'd2,
    CFG_FAULT_MASK = 3'd3,
    CFG_LISTEN     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] stale_limit_ms;
    logic [15:0] keepalive_period_ms;
    logic [7:0]  current_scale;
    logic [15:0] fault_mask;
    logic        listen_only;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [28:0] rx_id;
    logic [3:0]  rx_length;
    logic [63:0] rx_payload;
    logic [7:0]  drive_magnitude;
    logic        drive_reversed;
  } item_t;

  typedef struct packed {
    logic        healthy;
    logic [15:0] error_code;
    logic [15:0] current_ma;
    logic [15:0] peak_current_ma;
    logic [31:0] cumulative_degrees;
    logic        position_valid;
    logic [7:0]  commanded_pwm;
  } status_t;

  typedef struct packed {
    logic [1:0]  n_frames;
    logic [63:0] frame0;
    logic [63:0] frame1;
    status_t     status;
  } result_t;

  // speed word for each magnitude, one table per direction
  typedef logic [255:0][15:0] spd_tbl_t;

  function automatic spd_tbl_t gen_speed_tbl(input logic neg);
    spd_tbl_t t;
    int       s;
    int       v;
    for (int m = 0; m < 256; m++) begin
      s = neg ? -m : m;
      v = ((s + 255) * (SpeedMax - SpeedMin)) / 510 + SpeedMin;
      t[m] = v[15:0];
    end
    return t;
  endfunction

  localparam spd_tbl_t SpeedFwdTbl = gen_speed_tbl(1'b0);
  localparam spd_tbl_t SpeedRevTbl = gen_speed_tbl(1'b1);

endpackage

// ----- design/slhm_core.sv -----
module slhm_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  slhm_pkg::cfg_t  cfg_i,
  input  slhm_pkg::item_t item_i,
  input  logic            advance_i,
  output slhm_pkg::result_t result_o
);
  import slhm_pkg::*;

  logic        health_q, health_d;
  logic [15:0] age_q, age_d;
  logic [15:0] ka_q, ka_d;
  logic [15:0] err_q, err_d;
  logic [15:0] cur_q, cur_d;
  logic [15:0] peak_q, peak_d;
  logic        ref_q, ref_d;
  logic [15:0] prev_q, prev_d;
  logic [31:0] total_q, total_d;
  logic [7:0]  pwm_q, pwm_d;

  logic [15:0] hb_err, hb_raw, hb_ang, ang_diff, spd;
  logic [16:0] hb_mag, ka_next;
  logic [24:0] cur_prod;
  logic [15:0] hb_cur;
  logic        is_hb, healthy_now;
  logic [63:0] f0, f1, spd_frame;
  logic [1:0]  nfr;

  assign hb_err   = item_i.rx_payload[15:0];
  assign hb_raw   = item_i.rx_payload[31:16];
  assign hb_ang   = item_i.rx_payload[63:48];
  assign hb_mag   = hb_raw[15] ? (17'h1_0000 - {1'b0, hb_raw}) : {1'b0, hb_raw};
  assign cur_prod = 25'(hb_mag) * 25'(cfg_i.current_scale);
  assign hb_cur   = cur_prod[15:0];
  assign ang_diff = hb_ang - prev_q;
  assign ka_next  = {1'b0, ka_q} + 17'd1;
  assign is_hb    = (item_i.rx_id == HbId) && (item_i.rx_length >= 4'd8);
  assign healthy_now = health_q && (age_q <= cfg_i.stale_limit_ms);

  assign spd = item_i.drive_reversed ? SpeedRevTbl[item_i.drive_magnitude]
                                     : SpeedFwdTbl[item_i.drive_magnitude];
  assign spd_frame = FrameSpeed | {32'h0, spd, 16'h0} | (spd[15] ? 64'hFFFF : 64'h0);

  always_comb begin
    health_d = health_q;
    age_d    = age_q;
    ka_d     = ka_q;
    err_d    = err_q;
    cur_d    = cur_q;
    peak_d   = peak_q;
    ref_d    = ref_q;
    prev_d   = prev_q;
    total_d  = total_q;
    pwm_d    = pwm_q;
    f0       = '0;
    f1       = '0;
    nfr      = 2'd0;
    case (item_i.kind)
      KIND_RX: begin
        if (is_hb) begin
          prev_d = hb_ang;
          ref_d  = 1'b1;
          if (!ref_q) total_d = '0;
          else        total_d = total_q + {{16{ang_diff[15]}}, ang_diff};
          err_d  = hb_err;
          cur_d  = hb_cur;
          if (hb_cur > peak_q) peak_d = hb_cur;
          age_d    = '0;
          health_d = ((hb_err & cfg_i.fault_mask) == 16'h0);
        end
      end
      KIND_TICK: begin
        if (age_q != 16'hFFFF) age_d = age_q + 16'd1;
        if (ka_next > {1'b0, cfg_i.keepalive_period_ms}) begin
          ka_d = '0;
          if (pwm_q == 8'd0) begin
            f0  = FrameDisable;
            nfr = 2'd1;
          end
        end else begin
          ka_d = ka_next[15:0];
        end
        if (health_q && (age_d > cfg_i.stale_limit_ms)) health_d = 1'b0;
      end
      KIND_DRIVE: begin
        if (!healthy_now) begin
          f0    = FrameDisable;
          nfr   = 2'd1;
          pwm_d = '0;
        end else begin
          f1  = FrameEnable;
          nfr = 2'd2;
          if (item_i.drive_magnitude == 8'd0) begin
            f0    = FrameSpeed;
            pwm_d = '0;
          end else begin
            f0    = spd_frame;
            pwm_d = item_i.drive_magnitude;
          end
        end
      end
      KIND_STOP: begin
        f0    = FrameSpeed;
        f1    = FrameDisable;
        nfr   = 2'd2;
        pwm_d = '0;
      end
      KIND_PEAK_CLR: peak_d = '0;
      default: ;
    endcase
  end

  always_comb begin
    result_o.n_frames = cfg_i.listen_only ? 2'd0 : nfr;
    result_o.frame0   = f0;
    result_o.frame1   = f1;
    result_o.status.healthy            = health_d && (age_d <= cfg_i.stale_limit_ms);
    result_o.status.error_code         = err_d;
    result_o.status.current_ma         = cur_d;
    result_o.status.peak_current_ma    = peak_d;
    result_o.status.cumulative_degrees = total_d;
    result_o.status.position_valid     = ref_d;
    result_o.status.commanded_pwm      = pwm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      health_q <= 1'b0;
      age_q    <= '0;
      ka_q     <= '0;
      err_q    <= '0;
      cur_q    <= '0;
      peak_q   <= '0;
      ref_q    <= 1'b0;
      prev_q   <= '0;
      total_q  <= '0;
      pwm_q    <= '0;
    end else if (advance_i) begin
      health_q <= health_d;
      age_q    <= age_d;
      ka_q     <= ka_d;
      err_q    <= err_d;
      cur_q    <= cur_d;
      peak_q   <= peak_d;
      ref_q    <= ref_d;
      prev_q   <= prev_d;
      total_q  <= total_d;
      pwm_q    <= pwm_d;
    end
  end

endmodule

// ----- design/slhm_out_stage.sv -----
module slhm_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  slhm_pkg::result_t result_i,
  output logic              ready_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [slhm_pkg::OutTdataW-1:0] m_axis_tdata,  // see top level
  output logic              m_axis_tuser,
  output logic              m_axis_tlast
);
  import slhm_pkg::*;

  result_t res_q;
  logic    valid_q, valid_d;
  logic    beat_q, beat_d;
  logic    last_beat, frame_ok;
  logic [63:0] frame;

  // second beat exists only for two-frame results
  assign last_beat = beat_q || (res_q.n_frames != 2'd2);
  assign frame_ok  = beat_q ? (res_q.n_frames == 2'd2) : (res_q.n_frames != 2'd0);
  assign frame     = !frame_ok ? 64'h0 : (beat_q ? res_q.frame1 : res_q.frame0);
  assign ready_o   = !valid_q || (m_axis_tready && last_beat);

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = frame_ok;
  assign m_axis_tlast  = last_beat;
  assign m_axis_tdata  = {6'b0, res_q.status.commanded_pwm, res_q.status.position_valid,
                          res_q.status.cumulative_degrees, res_q.status.peak_current_ma,
                          res_q.status.current_ma, res_q.status.error_code,
                          res_q.status.healthy, frame};

  always_comb begin
    valid_d = valid_q;
    beat_d  = beat_q;
    if (load_i) begin
      valid_d = 1'b1;
      beat_d  = 1'b0;
    end else if (valid_q && m_axis_tready) begin
      if (last_beat) valid_d = 1'b0;
      else           beat_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      beat_q  <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= result_i;
  end

endmodule

// ----- design/servo_link_heartbeat_monitor_unit.sv -----
// servo link heartbeat monitor: takes one item per beat on the slave stream (received
// frame, millisecond tick, drive, stop or peak clear, chosen by s_axis_tuser), keeps
// the motor's latest error code, scaled current, peak current and unwrapped angle, and
// answers each item with one or two result beats on the master stream. m_axis_tuser
// high means the beat carries a command frame (identifier 0x06000001, length 8) in
// tdata[63:0]; a beat with m_axis_tuser low carries status only. Stop items and drive
// items while healthy give two beats, an unhealthy drive one disable beat, a tick may
// give one keep-alive disable beat, everything else a single status beat; tlast marks
// the final beat of an item and the status fields hold the same values in every beat
// of it. An item is held in the input register and evaluated in one pass into the
// result register; the result register drains one beat per cycle while m_axis_tready
// is high, which sets the sustained rate at one item per cycle for single-beat items,
// and it takes no new item until both beats of a two-frame item are taken.
// Configuration writes take effect at the next edge and are meant for when the block
// is idle; listen_only drops all frames while state still updates.
module servo_link_heartbeat_monitor_unit (
  input  logic clk_i,
  input  logic rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [slhm_pkg::CfgIdxW-1:0]        cfg_addr_i,
  input  logic [slhm_pkg::CfgDataW-1:0]       cfg_wdata_i,
  // item stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // rx_id[28:0], rx_length[32:29], rx_payload[96:33], drive_magnitude[104:97],
  // drive_reversed[105], zero fill above
  input  logic [slhm_pkg::InTdataW-1:0]       s_axis_tdata,
  // kind[2:0]
  input  logic [2:0]                          s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tx_payload[63:0], healthy[64], error_code[80:65], current_ma[96:81],
  // peak_current_ma[112:97], cumulative_degrees[144:113], position_valid[145],
  // commanded_pwm[153:146], zero fill above
  output logic [slhm_pkg::OutTdataW-1:0]      m_axis_tdata,
  // tx_valid
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);
  import slhm_pkg::*;

  cfg_t    cfg_q;
  item_t   item_q;
  logic    item_valid_q;
  logic    out_ready, advance, take;
  result_t result;

  // config registers, reset to the documented defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stale_limit_ms      <= 16'd200;
      cfg_q.keepalive_period_ms <= 16'd200;
      cfg_q.current_scale       <= 8'd1;
      cfg_q.fault_mask          <= 16'hBFFE;
      cfg_q.listen_only         <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_STALE:      cfg_q.stale_limit_ms      <= cfg_wdata_i;
        CFG_KEEPALIVE:  cfg_q.keepalive_period_ms <= cfg_wdata_i;
        CFG_SCALE:      cfg_q.current_scale       <= cfg_wdata_i[7:0];
        CFG_FAULT_MASK: cfg_q.fault_mask          <= cfg_wdata_i;
        CFG_LISTEN:     cfg_q.listen_only         <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input register: refills in the same cycle it hands its item on
  assign advance       = item_valid_q && out_ready;
  assign s_axis_tready = !item_valid_q || out_ready;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) item_valid_q <= 1'b0;
    else if (take) item_valid_q <= 1'b1;
    else if (advance) item_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.kind            <= s_axis_tuser;
      item_q.rx_id           <= s_axis_tdata[28:0];
      item_q.rx_length       <= s_axis_tdata[32:29];
      item_q.rx_payload      <= s_axis_tdata[96:33];
      item_q.drive_magnitude <= s_axis_tdata[104:97];
      item_q.drive_reversed  <= s_axis_tdata[105];
    end
  end

  // state update and frame building for the held item
  slhm_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .item_i    (item_q),
    .advance_i (advance),
    .result_o  (result)
  );

  // result register, one beat per frame, or a single status beat for an item without frames
  slhm_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .result_i      (result),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- design/slhm_checker.sv -----
module slhm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [slhm_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);

  // a status-only beat is always the single beat of its item
  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("status-only beat without tlast");

  // the second frame of an item follows right after the first
  a_second_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tuser)
    else $error("missing second frame beat");

  // status is the same in both beats of one item
  a_status_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> $stable(m_axis_tdata[153:64]))
    else $error("status changed within an item");

  // stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled beat changed");

endmodule

bind servo_link_heartbeat_monitor_unit slhm_checker u_slhm_checker (.*);
